// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Entry layout, operation and status codes, default depth.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEF = 128;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PRIO_W    = 32;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned STATUS_W  = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // broadcast command to every cell, already qualified by full/empty
  typedef struct packed {
    logic enq;
    logic deq;
  } ctl_t;

endpackage : spq_pkg

`default_nettype wire

// File: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift chain
// Holds one entry; shifts right on insert below it, left on a dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 8
) (
  input  wire logic             clk,
  input  wire ctl_t             ctl,
  input  wire logic [CNT_W-1:0] count,
  input  wire entry_t           new_ent,
  input  wire entry_t           left_ent,
  input  wire logic             left_ins,
  input  wire entry_t           right_ent,
  output entry_t                ent,
  output logic                  ins
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   occ;

  // occupied slots form a prefix of the chain
  assign occ = CNT_W'(IDX) < count;
  // new entry goes at or before this slot: slot empty or lower priority held
  assign ins = !occ || ($signed(ent_r.prio) < $signed(new_ent.prio));

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.enq && ins) begin
      ent_nxt = left_ins ? left_ent : new_ent;
    end else if (ctl.deq) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule : spq_cell

`default_nettype wire

// File: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: shift-array priority queue, highest priority first
// Result: registered, presented in the cycle after the input transaction.
// Throughput: one transaction per cycle unless a stalled result blocks input; every cell compares against the
//   broadcast priority and shifts in the same cycle.
// Reset: rst_n synchronous, clears the entry count and output valid; slot
//   contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_operation,
  input  wire logic signed [DATA_W-1:0]   in_data_in,
  input  wire logic signed [PRIO_W-1:0]   in_priority_in,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [DATA_W-1:0]        out_data_out,
  output logic signed [PRIO_W-1:0]        out_priority_out,
  output logic        [STATUS_W-1:0]      out_status,
  output logic        [COUNT_W-1:0]       out_count_out
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Handshake: a result waiting in the output register only blocks input
  // while the downstream side stalls it.
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic out_valid_r, out_valid_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Occupancy count
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full, empty;
  ctl_t             ctl;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;

  assign ctl.enq = in_acc && (in_operation == OP_ENQ) && !full;
  assign ctl.deq = in_acc && (in_operation == OP_DEQ) && !empty;

  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: slot 0 is the head. An insert shifts the lower-priority tail
  // one place toward the end; a dequeue shifts everything toward the head.
  // ---------------------------------------------------------------------------
  entry_t new_ent;
  entry_t ent [DEPTH];
  logic   ins [DEPTH];

  assign new_ent.data = in_data_in;
  assign new_ent.prio = in_priority_in;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_ins;

    if (g == 0) begin : g_head
      assign left_ent = new_ent;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[g-1];
      assign left_ins = ins[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = ent[g+1];
    end

    spq_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .left_ins  (left_ins),
      .right_ent (right_ent),
      .ent       (ent[g]),
      .ins       (ins[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0]   data_r, data_nxt;
  logic signed [PRIO_W-1:0]   prio_r, prio_nxt;
  logic        [STATUS_W-1:0] status_r, status_nxt;
  logic        [COUNT_W-1:0]  cnt_out_r, cnt_out_nxt;

  always_comb begin
    data_nxt    = '0;
    prio_nxt    = '0;
    status_nxt  = ST_DONE;
    cnt_out_nxt = COUNT_W'(count_nxt);
    if (in_operation == OP_ENQ) begin
      if (full) begin
        status_nxt = ST_FULL;
      end
    end else if (empty) begin
      status_nxt = ST_EMPTY;
    end else begin
      data_nxt = ent[0].data;
      prio_nxt = ent[0].prio;
    end
  end

  assign out_valid_nxt = in_acc ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r    <= data_nxt;
      prio_r    <= prio_nxt;
      status_r  <= status_nxt;
      cnt_out_r <= cnt_out_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_out     = data_r;
  assign out_priority_out = prio_r;
  assign out_status       = status_r;
  assign out_count_out    = cnt_out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> ($signed(ent[0].prio) >= $signed(ent[1].prio)))
    else $error("head entry out of priority order");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.deq |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("dequeue did not decrement count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_data_out == '0 &&
      out_priority_out == '0 && out_count_out == '0))
    else $error("empty dequeue result not zero");

endmodule : sorted_priority_queue

`default_nettype wire

// File: tb/sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// A queue of enqueue/dequeue transactions feeds a clocked driver. A scoreboard
// model of the sorted array predicts each result at input acceptance. A clocked
// monitor checks every output transaction field by field, in order. Both sides
// throttle at random, and a long output hold-off backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned QDEPTH       = DEPTH_DEF;
  localparam int unsigned ITEM_TARGET  = 1900;   // random part stops past this
  localparam int unsigned HOLD_CYCLES  = 300;    // long output hold-off
  localparam int unsigned DRAIN_CYCLES = 20;     // quiet cycles after last result
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // one input transaction as queued for the driver
  typedef struct {
    logic                     op;
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } op_txn_t;

  // one predicted output transaction
  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
  } result_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic                     in_operation   = OP_ENQ;
  logic signed [DATA_W-1:0] in_data_in     = '0;
  logic signed [PRIO_W-1:0] in_priority_in = '0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic signed [DATA_W-1:0] out_data_out;
  logic signed [PRIO_W-1:0] out_priority_out;
  logic [STATUS_W-1:0]      out_status;
  logic [COUNT_W-1:0]       out_count_out;

  sorted_priority_queue #(
    .DEPTH(QDEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_data_in      (in_data_in),
    .in_priority_in  (in_priority_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_out    (out_data_out),
    .out_priority_out(out_priority_out),
    .out_status      (out_status),
    .out_count_out   (out_count_out)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  op_txn_t op_backlog[$];       // transactions not yet offered to the block
  result_t awaited_results[$];  // predicted results, oldest first
  int      total_items  = 0;
  int      accepted_cnt = 0;    // input transactions taken by the block
  int      err_cnt      = 0;
  int      gen_count    = 0;    // occupancy seen by the stimulus generator
  int      cycle_cnt    = 0;
  int      hold_left    = 0;
  bit      hold_done    = 1'b0;

  // Scoreboard copy of the sorted array: head at index 0, highest priority.
  logic signed [DATA_W-1:0] held_data [QDEPTH];
  logic signed [PRIO_W-1:0] held_prio [QDEPTH];
  int                       held_count = 0;

  // Apply one transaction to the scoreboard array and return the result the
  // block must produce for it.
  function automatic result_t queue_apply(input logic op,
                                          input logic signed [DATA_W-1:0] d,
                                          input logic signed [PRIO_W-1:0] p);
    result_t r;
    int      i;
    r.data   = '0;
    r.prio   = '0;
    r.status = ST_DONE;
    if (op == OP_ENQ) begin
      if (held_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        // walk up from the tail; stop at the first entry of equal or higher
        // priority, so ties stay in arrival order (signed compare)
        i = held_count;
        while (i > 0 && held_prio[i-1] < p) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
          i--;
        end
        held_data[i] = d;
        held_prio[i] = p;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.data = held_data[0];
        r.prio = held_prio[0];
        for (i = 0; i + 1 < held_count; i++) begin
          held_data[i] = held_data[i+1];
          held_prio[i] = held_prio[i+1];
        end
        held_count--;
      end
    end
    r.count = COUNT_W'(held_count);
    return r;
  endfunction

  // Throttle phases follow progress through the stimulus:
  // receiver-heavy idling, then sender-heavy, then none.
  function automatic int phase_now();
    if (accepted_cnt * 3 < total_items) return 0;
    if (accepted_cnt * 3 < total_items * 2) return 1;
    return 2;
  endfunction

  function automatic int src_idle_pct();
    case (phase_now())
      0:       return 38;
      1:       return 57;
      default: return 0;
    endcase
  endfunction

  function automatic int snk_idle_pct();
    case (phase_now())
      0:       return 57;
      1:       return 38;
      default: return 0;
    endcase
  endfunction

  // Priorities lean on the extremes and a narrow band so ties are common.
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return PRIO_W'($signed($urandom_range(0, 7)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input logic op, input logic [DATA_W-1:0] d,
                        input logic [PRIO_W-1:0] p);
    op_txn_t t;
    t.op   = op;
    t.data = d;
    t.prio = p;
    op_backlog.push_back(t);
    if (op == OP_ENQ && gen_count < QDEPTH) gen_count++;
    if (op == OP_DEQ && gen_count > 0) gen_count--;
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: offers backlog transactions; a stalled payload is held as is.
  // The prediction is made at the edge the block takes the transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    op_txn_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(queue_apply(in_operation, in_data_in, in_priority_in));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (op_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct()) begin
          nxt = op_backlog.pop_front();
          in_valid       <= 1'b1;
          in_operation   <= nxt.op;
          in_data_in     <= nxt.data;
          in_priority_in <= nxt.prio;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each output transaction against the oldest prediction,
  // then picks the next stall. Halfway through, a long hold-off backs the
  // block up while the driver keeps offering.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon_proc
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("output transaction with nothing outstanding");
          err_cnt++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data_out !== want.data) begin
            $error("data_out: expected %0d, actual %0d", want.data, out_data_out);
            err_cnt++;
          end
          if (out_priority_out !== want.prio) begin
            $error("priority_out: expected %0d, actual %0d", want.prio, out_priority_out);
            err_cnt++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            err_cnt++;
          end
          if (out_count_out !== want.count) begin
            $error("count_out: expected %0d, actual %0d", want.count, out_count_out);
            err_cnt++;
          end
        end
      end
      if (!hold_done && accepted_cnt * 2 >= total_items) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < snk_idle_pct());
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sorted_priority_queue_test: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int n;
    int k;
    // directed: dequeue on empty, field extremes, ties at both priority ends
    add_op(OP_DEQ, $urandom, $urandom);
    add_op(OP_ENQ, 32'h7fff_ffff, 32'h0000_0000);
    add_op(OP_ENQ, 32'h8000_0000, 32'h7fff_ffff);
    add_op(OP_ENQ, 32'h0000_0000, 32'h8000_0000);
    add_op(OP_ENQ, 32'hffff_ffff, 32'hffff_ffff);
    add_op(OP_ENQ, 32'h0000_0001, 32'h0000_0000);   // tie, goes after
    add_op(OP_ENQ, 32'h0000_0002, 32'h7fff_ffff);   // tie at the top
    add_op(OP_ENQ, 32'h0000_0003, 32'h8000_0000);   // tie at the bottom
    add_op(OP_ENQ, 32'h5555_aaaa, 32'h0000_0001);
    for (k = 0; k < 9; k++) add_op(OP_DEQ, $urandom, $urandom);  // last one empty
    add_op(OP_ENQ, 32'haaaa_5555, 32'h8000_0000);
    add_op(OP_DEQ, 32'hffff_ffff, 32'hffff_ffff);

    // random: fill past full, drain past empty, and mixed runs
    while (op_backlog.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = QDEPTH - gen_count + $urandom_range(1, 3);
          for (k = 0; k < n; k++) add_op(OP_ENQ, $urandom, pick_prio());
        end
        2, 3: begin
          n = gen_count + $urandom_range(1, 3);
          for (k = 0; k < n; k++) add_op(OP_DEQ, $urandom, $urandom);
        end
        default: begin
          n = $urandom_range(10, 40);
          for (k = 0; k < n; k++) add_op(1'($urandom_range(0, 1)), $urandom, pick_prio());
        end
      endcase
    end
    total_items = op_backlog.size();

    while (accepted_cnt < total_items) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && awaited_results.size() == 0) begin
      $display("sorted_priority_queue_test: clean");
    end else begin
      $display("sorted_priority_queue_test: errors");
    end
    $finish;
  end

endmodule : sorted_priority_queue_test
